>>> rtl/a51_stream_cipher_core_defines.svh
// Assertion macros for the A5/1 cipher RTL.
`ifndef A51_STREAM_CIPHER_CORE_DEFINES_SVH
`define A51_STREAM_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk with async reset masked.
`define A51_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk with async reset masked.
`define A51_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/a51_pkg.sv
// Shared types and constants of the A5/1 stream cipher core.
package a51_pkg;

	// Default burst geometry
	localparam int BURST_LENGTH_DEF  = 114;
	localparam int WARMUP_CLOCKS_DEF = 100;

	// Frame setup: key bits then COUNT bits, one per clock
	localparam int KEY_BITS     = 64;
	localparam int COUNT_BITS   = 22;
	localparam int SETUP_CLOCKS = KEY_BITS + COUNT_BITS;
	localparam int FRAME_W      = 32;

	// LFSR feedback taps and clocking bit positions
	localparam logic [18:0] TAPS_ONE   = 19'h72000;
	localparam logic [21:0] TAPS_TWO   = 22'h300000;
	localparam logic [22:0] TAPS_THREE = 23'h700080;
	localparam int CLK_POS_ONE   = 8;
	localparam int CLK_POS_TWO   = 10;
	localparam int CLK_POS_THREE = 10;

	// COUNT fields: T1 = fn / 1326, T3 = fn mod 51, T2 = fn mod 26
	localparam int MOD_T2 = 26;
	localparam int MOD_T3 = 51;
	localparam int DIV_T1 = 26 * 51;
	localparam int T1_W   = 11;
	localparam int T3_W   = 6;
	localparam int T2_W   = 5;

	// Register map index (byte address bit 3)
	typedef enum logic {
		REG_CIPHER_KEY  = 1'b0,
		REG_START_FRAME = 1'b1
	} reg_idx_t;

	// Control of the three LFSRs for one clock
	typedef struct packed {
		logic clr;   // clear all registers
		logic load;  // clock all, XOR din into bit 0
		logic maj;   // majority clock
		logic din;   // setup bit
	} lfsr_ctl_t;

endpackage

>>> rtl/a51_lfsr.sv
// Three A5/1 LFSRs with load and majority clocking, one clock per cycle.
module a51_lfsr (
	input  logic                clk,
	input  logic                arst_n,
	input  a51_pkg::lfsr_ctl_t  ctl,
	output logic                ks_bit
);

	logic [18:0] r1_q;
	logic [21:0] r2_q;
	logic [22:0] r3_q;
	logic        c1, c2, c3, maj_v;
	logic        en1, en2, en3;
	logic [18:0] sh1;
	logic [21:0] sh2;
	logic [22:0] sh3;

	// Majority vote over the clocking bits
	assign c1    = r1_q[a51_pkg::CLK_POS_ONE];
	assign c2    = r2_q[a51_pkg::CLK_POS_TWO];
	assign c3    = r3_q[a51_pkg::CLK_POS_THREE];
	assign maj_v = (c1 & c2) | (c1 & c3) | (c2 & c3);

	assign en1 = ctl.load | (ctl.maj & (c1 == maj_v));
	assign en2 = ctl.load | (ctl.maj & (c2 == maj_v));
	assign en3 = ctl.load | (ctl.maj & (c3 == maj_v));

	// Shift left, parity of taps into bit 0, setup bit XORed in
	assign sh1 = {r1_q[17:0], (^(r1_q & a51_pkg::TAPS_ONE)) ^ (ctl.load & ctl.din)};
	assign sh2 = {r2_q[20:0], (^(r2_q & a51_pkg::TAPS_TWO)) ^ (ctl.load & ctl.din)};
	assign sh3 = {r3_q[21:0], (^(r3_q & a51_pkg::TAPS_THREE)) ^ (ctl.load & ctl.din)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
		end else if (ctl.clr) begin
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
		end else begin
			if (en1) r1_q <= sh1;
			if (en2) r2_q <= sh2;
			if (en3) r3_q <= sh3;
		end
	end

	// Output bit as it stands after this clock
	assign ks_bit = (en1 ? r1_q[17] : r1_q[18])
		^ (en2 ? r2_q[20] : r2_q[21])
		^ (en3 ? r3_q[21] : r3_q[22]);

endmodule

>>> rtl/a51_count.sv
// Bit-serial COUNT builder: frame number divided by 1326, mod 51 and mod 26.
module a51_count (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [a51_pkg::FRAME_W-1:0]        frame_num,
	output logic [a51_pkg::COUNT_BITS-1:0]     count,
	output logic                               busy
);

	localparam int STEP_W = $clog2(a51_pkg::FRAME_W);

	logic [a51_pkg::FRAME_W-1:0] fn_sh_q;
	logic [STEP_W-1:0]           step_q;
	logic                        busy_q;
	logic [a51_pkg::T2_W-1:0]    r26_q;
	logic [a51_pkg::T3_W-1:0]    r51_q;
	logic [a51_pkg::T1_W-1:0]    r1326_q;
	logic [a51_pkg::T1_W-1:0]    quot_q;

	logic [a51_pkg::T2_W:0]      t26;
	logic [a51_pkg::T3_W:0]      t51;
	logic [a51_pkg::T1_W:0]      t1326;
	logic                        qbit;
	logic                        b;

	// One restoring step per cycle, MSB of the frame number first
	assign b     = fn_sh_q[a51_pkg::FRAME_W-1];
	assign t26   = {r26_q, b};
	assign t51   = {r51_q, b};
	assign t1326 = {r1326_q, b};
	assign qbit  = t1326 >= (a51_pkg::T1_W+1)'(a51_pkg::DIV_T1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(a51_pkg::FRAME_W - 1)) busy_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			fn_sh_q <= frame_num;
			r26_q   <= '0;
			r51_q   <= '0;
			r1326_q <= '0;
			quot_q  <= '0;
		end else if (busy_q) begin
			fn_sh_q <= {fn_sh_q[a51_pkg::FRAME_W-2:0], 1'b0};
			r26_q   <= (t26 >= (a51_pkg::T2_W+1)'(a51_pkg::MOD_T2))
				? a51_pkg::T2_W'(t26 - (a51_pkg::T2_W+1)'(a51_pkg::MOD_T2))
				: a51_pkg::T2_W'(t26);
			r51_q   <= (t51 >= (a51_pkg::T3_W+1)'(a51_pkg::MOD_T3))
				? a51_pkg::T3_W'(t51 - (a51_pkg::T3_W+1)'(a51_pkg::MOD_T3))
				: a51_pkg::T3_W'(t51);
			r1326_q <= qbit
				? a51_pkg::T1_W'(t1326 - (a51_pkg::T1_W+1)'(a51_pkg::DIV_T1))
				: a51_pkg::T1_W'(t1326);
			quot_q  <= {quot_q[a51_pkg::T1_W-2:0], qbit};
		end
	end

	assign count = {quot_q, r51_q, r26_q};
	assign busy  = busy_q;

endmodule

>>> rtl/a51_stream_cipher_core.sv
// Top level of the A5/1 byte stream cipher: sequencer, registers and handshakes.
//
//   channel | signals                                       | beat
//   --------+-----------------------------------------------+----------------------------
//   in      | in_valid, in_stall, data_byte, last_of_message | one data byte
//   out     | out_valid, out_stall, out_byte                | one combined byte
//   cfg     | psel, penable, pwrite, paddr, pwdata, ...     | cipher_key @0, start_frame @8
//
// A byte inside a frame passes through accept, eight keystream bit slots and output load.
// The first byte of a frame first takes the key and COUNT load and the warm-up majority
// clocks of the single LFSR bank, which clocks one bit per cycle.
// Reset clears the LFSRs, frame state and both channels; no clearing pass.
// One byte is in work at a time; in_stall is high until it reaches the output
// register, which holds its beat while out_stall is high.
module a51_stream_cipher_core #(
	parameter int BURST_LENGTH  = a51_pkg::BURST_LENGTH_DEF,
	parameter int WARMUP_CLOCKS = a51_pkg::WARMUP_CLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_of_message,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte
);

	`include "a51_stream_cipher_core_defines.svh"

	localparam int BURST_BYTES = (BURST_LENGTH + 7) / 8;
	localparam int FRAME_BYTES = 2 * BURST_BYTES;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int BIB_W       = $clog2(BURST_BYTES + 1);
	localparam int STEP_MAX    = (WARMUP_CLOCKS > a51_pkg::SETUP_CLOCKS)
		? WARMUP_CLOCKS : a51_pkg::SETUP_CLOCKS;
	localparam int STEP_W      = $clog2(STEP_MAX + 1);
	localparam int FW          = a51_pkg::FRAME_W;
	localparam int KW          = a51_pkg::KEY_BITS;
	localparam int CW          = a51_pkg::COUNT_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_WARM  = 5'b00100,
		S_GEN   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [KW-1:0]       key_q;
	logic [FW-1:0]       start_frame_q;
	logic [FW-1:0]       frame_q;
	logic [POS_W-1:0]    pos_q;
	logic                open_q;
	logic [BIB_W-1:0]    bib_q;
	logic [7:0]          data_q;
	logic [7:0]          ks_q;
	logic [7:0]          res_q;
	logic [KW-1:0]       load_sh_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;

	logic                cfg_wr;
	a51_pkg::reg_idx_t   cfg_idx;
	logic                in_fire;
	logic                out_fire;
	logic                done_take;
	logic [POS_W-1:0]    pos_eff;
	logic [FW-1:0]       frame_eff;
	logic [POS_W:0]      pos_inc;
	logic                pos_wrap;
	logic                new_frame;
	logic [BIB_W-1:0]    bib_nxt;
	logic                gen_active;
	logic                gen_last;
	logic                ks_bit;
	logic                ks_bit_nxt;
	logic [CW-1:0]       cnt_count;
	logic                cnt_busy;
	a51_pkg::lfsr_ctl_t  lfsr_ctl;

	// Configuration registers
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = a51_pkg::reg_idx_t'(paddr[3]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q         <= '0;
			start_frame_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				a51_pkg::REG_CIPHER_KEY:  key_q         <= pwdata;
				a51_pkg::REG_START_FRAME: start_frame_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			a51_pkg::REG_CIPHER_KEY:  prdata = key_q;
			a51_pkg::REG_START_FRAME: prdata = {(64-FW)'(0), start_frame_q};
			default:                  prdata = '0;
		endcase
	end

	// Handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid & ~in_stall;
	assign out_fire  = out_valid_q & ~out_stall;
	assign done_take = (state_q == S_DONE) & (~out_valid_q | ~out_stall);

	// Message and frame position as seen by the accepted byte
	assign pos_eff   = open_q ? pos_q : '0;
	assign frame_eff = open_q ? frame_q : start_frame_q;
	assign pos_inc   = {1'b0, pos_eff} + 1'b1;
	assign pos_wrap  = pos_inc >= (POS_W+1)'(FRAME_BYTES);
	assign new_frame = in_fire & (pos_eff == '0);
	assign bib_nxt   = (pos_eff < POS_W'(BURST_BYTES))
		? BIB_W'(pos_eff) : BIB_W'(pos_eff - POS_W'(BURST_BYTES));

	// Keystream bit slot inside the burst; padding slots give zero
	assign gen_active = {bib_q, step_q[2:0]} < (BIB_W+3)'(BURST_LENGTH);
	assign gen_last   = step_q == STEP_W'(7);
	assign ks_bit_nxt = gen_active & ks_bit;

	// LFSR control per state
	always_comb begin
		lfsr_ctl = '0;
		case (state_q)
			S_IDLE:  lfsr_ctl.clr = new_frame;
			S_SETUP: begin
				lfsr_ctl.load = 1'b1;
				lfsr_ctl.din  = load_sh_q[0];
			end
			S_WARM:  lfsr_ctl.maj = 1'b1;
			S_GEN:   lfsr_ctl.maj = gen_active;
			S_DONE:  ;
			default: ;
		endcase
	end

	a51_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lfsr_ctl),
		.ks_bit (ks_bit)
	);

	a51_count u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (new_frame),
		.frame_num (frame_eff),
		.count     (cnt_count),
		.busy      (cnt_busy)
	);

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			frame_q <= '0;
			pos_q   <= '0;
			open_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						step_q  <= '0;
						state_q <= (pos_eff == '0) ? S_SETUP : S_GEN;
						open_q  <= ~last_of_message;
						pos_q   <= pos_wrap ? '0 : pos_inc[POS_W-1:0];
						frame_q <= pos_wrap ? frame_eff + 1'b1 : frame_eff;
					end
				end
				S_SETUP: begin
					if (step_q == STEP_W'(a51_pkg::SETUP_CLOCKS - 1)) begin
						step_q  <= '0;
						state_q <= (WARMUP_CLOCKS == 0) ? S_GEN : S_WARM;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_WARM: begin
					if (step_q == STEP_W'(WARMUP_CLOCKS - 1)) begin
						step_q  <= '0;
						state_q <= S_GEN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_GEN: begin
					step_q <= step_q + 1'b1;
					if (gen_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: byte, burst slot, setup bit shifter, keystream shifter, result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q    <= data_byte;
			bib_q     <= bib_nxt;
			load_sh_q <= key_q;
		end else if (state_q == S_SETUP) begin
			if (step_q == STEP_W'(KW - 1)) load_sh_q <= {(KW-CW)'(0), cnt_count};
			else load_sh_q <= {1'b0, load_sh_q[KW-1:1]};
		end
		if (state_q == S_GEN) begin
			ks_q <= {ks_q[6:0], ks_bit_nxt};
			if (gen_last) res_q <= data_q ^ {ks_q[6:0], ks_bit_nxt};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_take) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) out_byte_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	// Checks
	`A51_ASSERT_NOW(a_count_ready, (state_q == S_SETUP) && (step_q == STEP_W'(KW - 1)), !cnt_busy, "COUNT not ready at key/count boundary")
	`A51_ASSERT_NEXT(a_accept_starts, in_fire, (state_q == S_SETUP) || (state_q == S_GEN), "accepted beat did not start work")
	`A51_ASSERT_NEXT(a_done_holds, (state_q == S_DONE) && out_valid_q && out_stall, state_q == S_DONE, "result left DONE while output blocked")
	`A51_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q), "sequencer state not one-hot")

endmodule

>>> bench/a51_stream_cipher_core_checker.sv
// Checker for the A5/1 byte cipher: predicts each output byte and compares it.
`timescale 1ns / 1ps
module a51_stream_cipher_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_of_message,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	output int          fail_count,
	output int          pending
);

	localparam int BURST_BYTES = (a51_pkg::BURST_LENGTH_DEF + 7) / 8;
	localparam int FRAME_BYTES = 2 * BURST_BYTES;

	// shadow copy of the registers
	logic [63:0] key_cfg;
	logic [31:0] start_cfg;

	// predicted cipher state
	logic [18:0] reg_a;
	logic [21:0] reg_b;
	logic [22:0] reg_c;
	logic [31:0] frame_no;
	int unsigned byte_pos;
	bit          msg_open;

	logic [7:0] expected_bytes[$];
	int         mismatches;

	// one clock of the LFSR bank; all = 1 clocks every register
	task clock_bank(input bit all);
		bit ca, cb, cc, mj;
		ca = reg_a[a51_pkg::CLK_POS_ONE];
		cb = reg_b[a51_pkg::CLK_POS_TWO];
		cc = reg_c[a51_pkg::CLK_POS_THREE];
		mj = (ca & cb) | (ca & cc) | (cb & cc);
		if (all || ca == mj)
			reg_a = {reg_a[17:0], ^(reg_a & a51_pkg::TAPS_ONE)};
		if (all || cb == mj)
			reg_b = {reg_b[20:0], ^(reg_b & a51_pkg::TAPS_TWO)};
		if (all || cc == mj)
			reg_c = {reg_c[21:0], ^(reg_c & a51_pkg::TAPS_THREE)};
	endtask

	// clear, load key then COUNT, then warm up
	task rebuild_frame();
		logic [31:0] t1, t2, t3, cnt_full;
		logic [21:0] cnt;
		t1 = frame_no / a51_pkg::DIV_T1;
		t2 = frame_no % a51_pkg::MOD_T2;
		t3 = frame_no % a51_pkg::MOD_T3;
		cnt_full = (t1 << 11) | (t3 << 5) | t2;
		cnt = cnt_full[21:0];
		reg_a = '0;
		reg_b = '0;
		reg_c = '0;
		for (int i = 0; i < a51_pkg::KEY_BITS; i++) begin
			clock_bank(1'b1);
			reg_a[0] = reg_a[0] ^ key_cfg[i];
			reg_b[0] = reg_b[0] ^ key_cfg[i];
			reg_c[0] = reg_c[0] ^ key_cfg[i];
		end
		for (int i = 0; i < a51_pkg::COUNT_BITS; i++) begin
			clock_bank(1'b1);
			reg_a[0] = reg_a[0] ^ cnt[i];
			reg_b[0] = reg_b[0] ^ cnt[i];
			reg_c[0] = reg_c[0] ^ cnt[i];
		end
		for (int i = 0; i < a51_pkg::WARMUP_CLOCKS_DEF; i++)
			clock_bank(1'b0);
	endtask

	// expected output byte for one input beat
	task cipher_byte(input logic [7:0] din, input logic last, output logic [7:0] dout);
		int unsigned base;
		logic [7:0] ks;
		if (!msg_open) begin
			frame_no = start_cfg;
			byte_pos = 0;
		end
		if (byte_pos == 0)
			rebuild_frame();
		base = (byte_pos < BURST_BYTES) ? byte_pos * 8 : (byte_pos - BURST_BYTES) * 8;
		ks = '0;
		// bits past the burst length stay zero
		for (int k = 0; k < 8; k++) begin
			if (base + k < a51_pkg::BURST_LENGTH_DEF) begin
				clock_bank(1'b0);
				ks[7 - k] = reg_a[18] ^ reg_b[21] ^ reg_c[22];
			end
		end
		dout = din ^ ks;
		byte_pos++;
		if (byte_pos >= FRAME_BYTES) begin
			byte_pos = 0;
			frame_no = frame_no + 32'd1;
		end
		msg_open = !last;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			key_cfg = '0;
			start_cfg = '0;
			reg_a = '0;
			reg_b = '0;
			reg_c = '0;
			frame_no = '0;
			byte_pos = 0;
			msg_open = 1'b0;
			expected_bytes.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (a51_pkg::reg_idx_t'(paddr[3]))
					a51_pkg::REG_CIPHER_KEY: begin
						key_cfg = pwdata;
					end
					a51_pkg::REG_START_FRAME: begin
						start_cfg = pwdata[31:0];
					end
					default: ;
				endcase
			end
			// output beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected out_byte %02h", $realtime, out_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: out_byte expected %02h actual %02h",
								$realtime, want, out_byte);
					end
				end
			end
			// input beat: predict its result
			if (in_valid && !in_stall) begin
				cipher_byte(data_byte, last_of_message, want);
				expected_bytes.push_back(want);
			end
			fail_count <= mismatches;
			pending <= expected_bytes.size();
		end
	end

endmodule

>>> bench/a51_stream_cipher_core_tb.sv
// Testbench top for the A5/1 byte cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module a51_stream_cipher_core_tb;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 75;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        last_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        calm = 1'b0;
	int          fail_count;
	int          pending;

	a51_stream_cipher_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_of_message(last_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte)
	);

	a51_stream_cipher_core_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_of_message(last_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.fail_count(fail_count),
		.pending(pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure, off during the calm stretch
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 23);
	end

	// setup phase, access phase, then idle with psel low
	task write_reg(input a51_pkg::reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// one input beat, with random idle cycles ahead of it
	task push_byte(input logic [7:0] d, input logic last);
		if (!calm) begin
			while ($urandom_range(0, 99) < 23) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		data_byte <= d;
		last_of_message <= last;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the sender until every predicted byte has come out
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int  left;
		int  len;
		bit  close;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-ones key, frame number at the wrap point
		write_reg(a51_pkg::REG_CIPHER_KEY, '1);
		write_reg(a51_pkg::REG_START_FRAME, 64'h0000_0000_FFFF_FFFF);
		// single-byte messages restart at the start frame each time
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hA5, 1'b1);
		// open message across the downlink padding byte
		for (int i = 0; i < 16; i++)
			push_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
		drain();
		// writes mid-message: start frame waits for the next message
		write_reg(a51_pkg::REG_START_FRAME, 64'd0);
		write_reg(a51_pkg::REG_CIPHER_KEY, 64'd0);
		for (int i = 0; i < 6; i++)
			push_byte(8'($urandom_range(0, 255)), i == 5);

		// random phases, registers changed while idle between them
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case ($urandom_range(0, 3))
				0: write_reg(a51_pkg::REG_CIPHER_KEY, 64'd0);
				1: write_reg(a51_pkg::REG_CIPHER_KEY, '1);
				default: write_reg(a51_pkg::REG_CIPHER_KEY, {$urandom, $urandom});
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(a51_pkg::REG_START_FRAME, 64'd0);
				1: write_reg(a51_pkg::REG_START_FRAME, 64'h0000_0000_FFFF_FFFF);
				2: write_reg(a51_pkg::REG_START_FRAME,
					64'(32'hFFFF_FFFF - $urandom_range(0, 2)));
				3: write_reg(a51_pkg::REG_START_FRAME, 64'($urandom_range(0, 5000)));
				default: write_reg(a51_pkg::REG_START_FRAME, 64'($urandom));
			endcase
			calm <= (ph == 3);
			left = PHASE_ITEMS;
			while (left > 0) begin
				// mostly messages that cross frame boundaries, some short ones
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(25, 70);
				if (len > left)
					len = left;
				for (int j = 0; j < len; j++) begin
					close = (j == len - 1) || ($urandom_range(0, 19) == 0);
					// the phase may end inside an open message
					if (len == left && j == len - 1)
						close = $urandom_range(0, 1);
					push_byte(8'($urandom_range(0, 255)), close);
				end
				left -= len;
			end
		end

		drain();
		calm <= 1'b0;
		repeat (250) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> a51_stream_cipher_core.f
+incdir+rtl
rtl/a51_pkg.sv
rtl/a51_lfsr.sv
rtl/a51_count.sv
rtl/a51_stream_cipher_core.sv
bench/a51_stream_cipher_core_checker.sv
bench/a51_stream_cipher_core_tb.sv
